FILE: rtl/bdc_pkg.sv
// Shared types and constants for the UART baud divisor calculator.
`default_nettype none

package bdc_pkg;

    localparam int PCLK_W = 28;
    localparam int BAUD_W = 24;
    localparam int WORD_W = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    // 25 * pclk needs 33 bits; divisor is 4 * baud at most
    localparam int NUM_W = 33;
    localparam int DEN_W = 26;
    localparam int QUO_W = 32;

    localparam int STEPS_PER_CELL = 3;
    localparam int NUM_CELLS = NUM_W / STEPS_PER_CELL;

    localparam logic [PCLK_W-1:0] PCLK_RESET = 28'd16000000;

    localparam logic [CFG_IDX_W-1:0] REG_PCLK_HZ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE_BY_8 = 1'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAUD_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MANT_RANGE = 2'd2;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for any 32-bit x
    localparam int RECIP_W = 31;
    localparam logic [RECIP_W-1:0] RECIP_100 = 31'h51EB851F;
    localparam int RECIP_SHIFT = 37;
    localparam int PROD_W = QUO_W + RECIP_W;
    localparam int MANT_W = PROD_W - RECIP_SHIFT;

    localparam int REM_W = 7;
    localparam logic [REM_W-1:0] SCALE_100 = 7'd100;
    localparam logic [MANT_W-1:0] MANT_LIMIT = 26'd4095;

    // rounded fraction: v < 2048, floor(v / 100) = (v * 1311) >> 17
    localparam int RND_W = 11;
    localparam logic [RND_W-1:0] ROUND_HALF = 11'd50;
    localparam logic [RND_W-1:0] FRAC_RECIP = 11'd1311;
    localparam int FRAC_SHIFT = 17;
    localparam int FRAC_PROD_W = 2 * RND_W;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;
        logic [DEN_W-1:0] den;
        logic             os8;
        logic             zero;
    } div_data_t;

    typedef struct packed {
        logic [QUO_W-1:0] q;
        logic             os8;
        logic             zero;
    } quo_data_t;

endpackage

`default_nettype wire

FILE: rtl/uart_baud_divisor_calc.sv
// Top level of the UART fractional baud divisor calculator: config, prep, divider, post.
//
//   channel   | signals                                  | direction
//   ----------+------------------------------------------+----------
//   request   | baud_valid, baud_stall, baud_rate        | in
//   result    | result_valid, result_stall,              | out
//             | divisor_word, status                     |
//   config    | cfg_write, cfg_index, cfg_data           | in
//
// One request per cycle sustained while result_stall is low; the path is a prep stage,
// 11 divider cells of 3 restoring steps each (33-bit quotient), and 3 post stages.
// Reset empties the pipeline and loads pclk_hz = 16000000, oversample by 16.
// Each stage takes a new request when empty or when its successor moves, so bubbles
// close up under result stalls; baud_stall rises only when the prep stage is held.
`default_nettype none

module uart_baud_divisor_calc (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           baud_valid,
    output logic                                baud_stall,
    input  wire logic [bdc_pkg::BAUD_W-1:0]     baud_rate,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic [bdc_pkg::WORD_W-1:0]          divisor_word,
    output logic [bdc_pkg::STATUS_W-1:0]        status,
    input  wire logic                           cfg_write,
    input  wire logic [bdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bdc_pkg::PCLK_W-1:0]     cfg_data
);

    logic [bdc_pkg::PCLK_W-1:0]  pclk_reg;
    logic [bdc_pkg::PCLK_W-1:0]  pclk_next;
    logic                        os8_reg;
    logic                        os8_next;

    logic                        prep_valid_reg;
    logic                        prep_valid_next;
    bdc_pkg::div_data_t          prep_data_reg;
    bdc_pkg::div_data_t          prep_data_next;
    logic                        prep_ready;

    logic                        stage_valid [bdc_pkg::NUM_CELLS+1];
    bdc_pkg::div_data_t          stage_data  [bdc_pkg::NUM_CELLS+1];
    logic                        stage_ready [1:bdc_pkg::NUM_CELLS+1];
    logic                        post_ready;

    bdc_pkg::quo_data_t          quo_data;

    always_comb
    begin
        pclk_next = pclk_reg;
        os8_next = os8_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                bdc_pkg::REG_PCLK_HZ:         pclk_next = cfg_data;
                bdc_pkg::REG_OVERSAMPLE_BY_8: os8_next = cfg_data[0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pclk_reg <= bdc_pkg::PCLK_RESET;
            os8_reg <= 1'b0;
        end
        else
        begin
            pclk_reg <= pclk_next;
            os8_reg <= os8_next;
        end
    end

    // numerator 25 * pclk, divisor 2 * baud (by 8) or 4 * baud (by 16)
    always_comb
    begin
        prep_data_next.rem = '0;
        prep_data_next.nq =
            {{(bdc_pkg::NUM_W-bdc_pkg::PCLK_W-4){1'b0}}, pclk_reg, 4'b0}
          + {{(bdc_pkg::NUM_W-bdc_pkg::PCLK_W-3){1'b0}}, pclk_reg, 3'b0}
          + {{(bdc_pkg::NUM_W-bdc_pkg::PCLK_W){1'b0}}, pclk_reg};
        if (os8_reg)
        begin
            prep_data_next.den = {1'b0, baud_rate, 1'b0};
        end
        else
        begin
            prep_data_next.den = {baud_rate, 2'b0};
        end
        prep_data_next.os8 = os8_reg;
        prep_data_next.zero = (baud_rate == '0);
    end

    assign prep_ready = !prep_valid_reg || stage_ready[1];
    assign prep_valid_next = prep_ready ? baud_valid : prep_valid_reg;
    assign baud_stall = !prep_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else
        begin
            prep_valid_reg <= prep_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prep_ready && baud_valid)
        begin
            prep_data_reg <= prep_data_next;
        end
    end

    assign stage_valid[0] = prep_valid_reg;
    assign stage_data[0] = prep_data_reg;
    assign stage_ready[bdc_pkg::NUM_CELLS+1] = post_ready;

    for (genvar k = 1; k <= bdc_pkg::NUM_CELLS; k++)
    begin : g_cell
        bdc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[k-1]),
            .up_data  (stage_data[k-1]),
            .up_ready (stage_ready[k]),
            .dn_valid (stage_valid[k]),
            .dn_data  (stage_data[k]),
            .dn_ready (stage_ready[k+1])
        );
    end

    always_comb
    begin
        quo_data.q = stage_data[bdc_pkg::NUM_CELLS].nq[bdc_pkg::QUO_W-1:0];
        quo_data.os8 = stage_data[bdc_pkg::NUM_CELLS].os8;
        quo_data.zero = stage_data[bdc_pkg::NUM_CELLS].zero;
    end

    bdc_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (stage_valid[bdc_pkg::NUM_CELLS]),
        .up_data      (quo_data),
        .up_ready     (post_ready),
        .dn_valid     (result_valid),
        .divisor_word (divisor_word),
        .status       (status),
        .dn_ready     (!result_stall)
    );

`ifndef SYNTHESIS
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        baud_stall |-> (prep_valid_reg && stage_valid[1]))
        else $error("request stalled while divider front has room");
`endif

endmodule

`default_nettype wire

FILE: rtl/bdc_div_cell.sv
// One cell of the divider chain: a few restoring division steps and a stage register.
`default_nettype none

module bdc_div_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              up_valid,
    input  wire bdc_pkg::div_data_t up_data,
    output logic                   up_ready,
    output logic                   dn_valid,
    output bdc_pkg::div_data_t     dn_data,
    input  wire logic              dn_ready
);

    logic                         valid_reg;
    logic                         valid_next;
    bdc_pkg::div_data_t           data_reg;
    bdc_pkg::div_data_t           data_next;
    logic [bdc_pkg::DEN_W:0]      trial;
    logic [bdc_pkg::DEN_W:0]      diff;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        data_next = up_data;
        trial = '0;
        diff = '0;
        for (int s = 0; s < bdc_pkg::STEPS_PER_CELL; s++)
        begin
            trial = {data_next.rem, data_next.nq[bdc_pkg::NUM_W-1]};
            diff = trial - {1'b0, data_next.den};
            if (trial >= {1'b0, data_next.den})
            begin
                data_next.rem = diff[bdc_pkg::DEN_W-1:0];
                data_next.nq = {data_next.nq[bdc_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem = trial[bdc_pkg::DEN_W-1:0];
                data_next.nq = {data_next.nq[bdc_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data = data_reg;

`ifndef SYNTHESIS
    // partial remainder stays below the divisor whenever the divisor is nonzero
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (data_reg.den != '0)) |-> (data_reg.rem < data_reg.den))
        else $error("divider cell remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: rtl/bdc_post.sv
// Mantissa split, remainder scaling and status: three pipeline stages after the divider.
`default_nettype none

module bdc_post (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    input  wire bdc_pkg::quo_data_t up_data,
    output logic                    up_ready,
    output logic                    dn_valid,
    output logic [bdc_pkg::WORD_W-1:0]   divisor_word,
    output logic [bdc_pkg::STATUS_W-1:0] status,
    input  wire logic               dn_ready
);

    // stage A: mantissa by reciprocal multiply
    logic                             a_valid_reg;
    logic                             a_valid_next;
    logic [bdc_pkg::QUO_W-1:0]        a_q_reg;
    logic [bdc_pkg::MANT_W-1:0]       a_mant_reg;
    logic [bdc_pkg::MANT_W-1:0]       a_mant_next;
    logic                             a_os8_reg;
    logic                             a_zero_reg;
    logic [bdc_pkg::PROD_W-1:0]       a_prod;

    // stage B: remainder
    logic                             b_valid_reg;
    logic                             b_valid_next;
    logic [bdc_pkg::MANT_W-1:0]       b_mant_reg;
    logic [bdc_pkg::REM_W-1:0]        b_rem_reg;
    logic [bdc_pkg::REM_W-1:0]        b_rem_next;
    logic                             b_os8_reg;
    logic                             b_zero_reg;
    logic [bdc_pkg::QUO_W-1:0]        b_mant_x100;
    logic [bdc_pkg::QUO_W-1:0]        b_rem_full;

    // stage C: rounded fraction and result
    logic                             c_valid_reg;
    logic                             c_valid_next;
    logic [bdc_pkg::WORD_W-1:0]       c_word_reg;
    logic [bdc_pkg::WORD_W-1:0]       c_word_next;
    logic [bdc_pkg::STATUS_W-1:0]     c_status_reg;
    logic [bdc_pkg::STATUS_W-1:0]     c_status_next;
    logic [bdc_pkg::RND_W-1:0]        c_round;
    logic [bdc_pkg::FRAC_PROD_W-1:0]  c_frac_prod;
    logic [4:0]                       c_frac;
    logic [3:0]                       c_frac_masked;

    logic a_ready;
    logic b_ready;
    logic c_ready;

    assign c_ready = !c_valid_reg || dn_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign up_ready = a_ready;

    assign a_valid_next = a_ready ? up_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;

    always_comb
    begin
        a_prod = {{bdc_pkg::RECIP_W{1'b0}}, up_data.q}
               * {{bdc_pkg::QUO_W{1'b0}}, bdc_pkg::RECIP_100};
        a_mant_next = a_prod[bdc_pkg::PROD_W-1 -: bdc_pkg::MANT_W];
    end

    always_comb
    begin
        b_mant_x100 = {a_mant_reg, 6'b0} + {1'b0, a_mant_reg, 5'b0}
                    + {4'b0, a_mant_reg, 2'b0};
        b_rem_full = a_q_reg - b_mant_x100;
        b_rem_next = b_rem_full[bdc_pkg::REM_W-1:0];
    end

    always_comb
    begin
        if (b_os8_reg)
        begin
            c_round = {1'b0, b_rem_reg, 3'b0} + bdc_pkg::ROUND_HALF;
        end
        else
        begin
            c_round = {b_rem_reg, 4'b0} + bdc_pkg::ROUND_HALF;
        end
        c_frac_prod = {{bdc_pkg::RND_W{1'b0}}, c_round}
                    * {{bdc_pkg::RND_W{1'b0}}, bdc_pkg::FRAC_RECIP};
        c_frac = c_frac_prod[bdc_pkg::FRAC_SHIFT +: 5];
        // carry out of the fraction is dropped by the mask
        c_frac_masked = b_os8_reg ? {1'b0, c_frac[2:0]} : c_frac[3:0];

        if (b_zero_reg)
        begin
            c_word_next = '0;
            c_status_next = bdc_pkg::STATUS_BAUD_ZERO;
        end
        else
        begin
            c_word_next = {b_mant_reg[11:0], c_frac_masked};
            c_status_next = (b_mant_reg > bdc_pkg::MANT_LIMIT) ?
                            bdc_pkg::STATUS_MANT_RANGE : bdc_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && up_valid)
        begin
            a_q_reg <= up_data.q;
            a_mant_reg <= a_mant_next;
            a_os8_reg <= up_data.os8;
            a_zero_reg <= up_data.zero;
        end
        if (b_ready && a_valid_reg)
        begin
            b_mant_reg <= a_mant_reg;
            b_rem_reg <= b_rem_next;
            b_os8_reg <= a_os8_reg;
            b_zero_reg <= a_zero_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            c_word_reg <= c_word_next;
            c_status_reg <= c_status_next;
        end
    end

    assign dn_valid = c_valid_reg;
    assign divisor_word = c_word_reg;
    assign status = c_status_reg;

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_rem_reg < bdc_pkg::SCALE_100))
        else $error("remainder after mantissa split out of range");

    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && (c_status_reg == bdc_pkg::STATUS_BAUD_ZERO))
        |-> (c_word_reg == '0))
        else $error("zero baud rate request with nonzero divisor word");
`endif

endmodule

`default_nettype wire
